@@ rtl/jsm_pkg.sv @@
package jsm_pkg;

	localparam int DATA_W     = 32;
	localparam int LEN_W      = 6;
	localparam int SCAN_WIDTH = 32;
	localparam int RESET_ONES = 5;
	localparam int IDX_W      = $clog2(DATA_W);
	localparam int TAP_W      = 4;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_RESET   = 2'd1,
		OP_IR_SCAN = 2'd2,
		OP_DR_SCAN = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RESET = 2'd1,
		PH_SCAN  = 2'd2
	} phase_t;

	typedef enum logic [TAP_W-1:0] {
		TAP_RESET     = 4'd0,
		TAP_IDLE      = 4'd1,
		TAP_SEL_DR    = 4'd2,
		TAP_CAP_DR    = 4'd3,
		TAP_SHIFT_DR  = 4'd4,
		TAP_EXIT1_DR  = 4'd5,
		TAP_PAUSE_DR  = 4'd6,
		TAP_EXIT2_DR  = 4'd7,
		TAP_UPDATE_DR = 4'd8,
		TAP_SEL_IR    = 4'd9,
		TAP_CAP_IR    = 4'd10,
		TAP_SHIFT_IR  = 4'd11,
		TAP_EXIT1_IR  = 4'd12,
		TAP_PAUSE_IR  = 4'd13,
		TAP_EXIT2_IR  = 4'd14,
		TAP_UPDATE_IR = 4'd15
	} tap_state_t;

	// IEEE 1149.1 TAP state transition on one TCK rising edge
	function automatic tap_state_t tap_next(input tap_state_t cur, input logic tms);
		tap_state_t nxt;
		nxt = TAP_RESET;
		unique case (cur)
			TAP_RESET:     nxt = tms ? TAP_RESET     : TAP_IDLE;
			TAP_IDLE:      nxt = tms ? TAP_SEL_DR    : TAP_IDLE;
			TAP_SEL_DR:    nxt = tms ? TAP_SEL_IR    : TAP_CAP_DR;
			TAP_CAP_DR:    nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
			TAP_SHIFT_DR:  nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
			TAP_EXIT1_DR:  nxt = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
			TAP_PAUSE_DR:  nxt = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
			TAP_EXIT2_DR:  nxt = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
			TAP_UPDATE_DR: nxt = tms ? TAP_SEL_DR    : TAP_IDLE;
			TAP_SEL_IR:    nxt = tms ? TAP_RESET     : TAP_CAP_IR;
			TAP_CAP_IR:    nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
			TAP_SHIFT_IR:  nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
			TAP_EXIT1_IR:  nxt = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
			TAP_PAUSE_IR:  nxt = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
			TAP_EXIT2_IR:  nxt = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
			TAP_UPDATE_IR: nxt = tms ? TAP_SEL_DR    : TAP_IDLE;
			default:       nxt = TAP_RESET;
		endcase
		return nxt;
	endfunction

endpackage

@@ rtl/jsm_if.sv @@
interface jsm_cmd_if;
	jsm_pkg::opcode_t                 opcode;
	logic [jsm_pkg::DATA_W-1:0]       scan_data;
	logic [jsm_pkg::LEN_W-1:0]        scan_length;
	logic                             tdo_bit;
	logic                             valid;
	logic                             ready;

	modport source (output opcode, scan_data, scan_length, tdo_bit, valid, input ready);
	modport sink   (input opcode, scan_data, scan_length, tdo_bit, valid, output ready);
endinterface

interface jsm_res_if;
	logic                             tms_out;
	logic                             tdi_out;
	logic                             clock_pulse;
	logic                             busy_res;
	logic                             done_res;
	logic [jsm_pkg::DATA_W-1:0]       read_data;
	logic                             rejected;
	logic [jsm_pkg::TAP_W-1:0]        tap_position;
	logic                             valid;
	logic                             ready;

	modport source (output tms_out, tdi_out, clock_pulse, busy_res, done_res, read_data,
		rejected, tap_position, valid, input ready);
	modport sink   (input tms_out, tdi_out, clock_pulse, busy_res, done_res, read_data,
		rejected, tap_position, valid, output ready);
endinterface

@@ rtl/jtag_scan_master.sv @@
// A word taken on cmd passes through the input register and then the result register before it is presented on res.
// Throughput: one word per cycle while res does not stall; the TAP bookkeeping and the one-bit shift are combinational.
// The input register refills while a finished result still waits, so stalls cost no bubbles.
// Reset (arst_n low): TAP tracked in Test-Logic-Reset, no sequence armed, both stages empty,
// shift and capture registers zero.
module jtag_scan_master (
	input logic      clk,
	input logic      arst_n,
	jsm_cmd_if.sink  cmd,
	jsm_res_if.source res
);
	import jsm_pkg::*;

	// input stage
	logic                valid_s1;
	opcode_t             op_s1;
	logic [DATA_W-1:0]   data_s1;
	logic [LEN_W-1:0]    len_s1;
	logic                tdo_s1;

	// sequencing state
	tap_state_t          tap_q;
	phase_t              phase_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [DATA_W-1:0]   shift_q;
	logic [DATA_W-1:0]   cap_q;
	logic                is_ir_q;
	logic [LEN_W-1:0]    bits_q;

	// result register
	logic                res_valid_q;
	logic                tms_q, tdi_q, pulse_q, busy_q, done_q, rej_q;
	logic [DATA_W-1:0]   rdata_q;
	tap_state_t          pos_q;

	// next values
	tap_state_t          tap_d;
	phase_t              phase_d;
	logic [LEN_W-1:0]    cnt_d;
	logic [DATA_W-1:0]   shift_d;
	logic [DATA_W-1:0]   cap_d;
	logic                is_ir_d;
	logic [LEN_W-1:0]    bits_d;
	logic                tms, tdi, pulse, done, rej;
	logic [LEN_W-1:0]    len_clamp;
	logic [LEN_W-1:0]    cnt_inc;
	logic                advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cnt_inc   = cnt_q + LEN_W'(1);

	always_comb begin
		if (len_s1 == '0) begin
			len_clamp = LEN_W'(1);
		end else if (len_s1 > LEN_W'(SCAN_WIDTH)) begin
			len_clamp = LEN_W'(SCAN_WIDTH);
		end else begin
			len_clamp = len_s1;
		end
	end

	// TMS, TDI, pulse, done and reject for the current word
	always_comb begin
		tms   = 1'b0;
		tdi   = 1'b0;
		pulse = 1'b0;
		done  = 1'b0;
		rej   = 1'b0;
		if (op_s1 != OP_TICK) begin
			rej = (phase_q != PH_IDLE);
		end else if (phase_q == PH_RESET) begin
			pulse = 1'b1;
			if (cnt_q < LEN_W'(RESET_ONES)) begin
				tms = 1'b1;
			end else begin
				done = 1'b1;
			end
		end else if (phase_q == PH_SCAN) begin
			pulse = 1'b1;
			unique case (tap_q) inside
				TAP_RESET: tms = 1'b0;
				TAP_IDLE: tms = 1'b1;
				TAP_SEL_DR: tms = is_ir_q;
				TAP_SEL_IR, TAP_CAP_DR, TAP_CAP_IR: tms = 1'b0;
				TAP_SHIFT_DR, TAP_SHIFT_IR: begin
					tdi = shift_q[0];
					tms = (cnt_inc >= bits_q);
				end
				TAP_UPDATE_DR, TAP_UPDATE_IR: begin
					tms  = 1'b0;
					done = 1'b1;
				end
				TAP_EXIT1_DR, TAP_PAUSE_DR, TAP_EXIT2_DR,
				TAP_EXIT1_IR, TAP_PAUSE_IR, TAP_EXIT2_IR: tms = 1'b1;
				default: tms = 1'b1;
			endcase
		end
	end

	// next state of the sequencer and the TAP tracker
	always_comb begin
		tap_d   = tap_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		shift_d = shift_q;
		cap_d   = cap_q;
		is_ir_d = is_ir_q;
		bits_d  = bits_q;
		if (op_s1 != OP_TICK) begin
			if (phase_q == PH_IDLE) begin
				cnt_d = '0;
				if (op_s1 == OP_RESET) begin
					phase_d = PH_RESET;
				end else begin
					phase_d = PH_SCAN;
					is_ir_d = (op_s1 == OP_IR_SCAN);
					bits_d  = len_clamp;
					shift_d = data_s1;
					cap_d   = '0;
				end
			end
		end else if (pulse) begin
			tap_d = tap_next(tap_q, tms);
			if (phase_q == PH_RESET && tms) begin
				cnt_d = cnt_inc;
			end
			if (phase_q == PH_SCAN && (tap_q == TAP_SHIFT_DR || tap_q == TAP_SHIFT_IR)) begin
				shift_d = shift_q >> 1;
				cap_d[cnt_q[IDX_W-1:0]] = cap_q[cnt_q[IDX_W-1:0]] | tdo_s1;
				cnt_d = cnt_inc;
			end
			if (done) begin
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1   <= cmd.opcode;
			data_s1 <= cmd.scan_data;
			len_s1  <= cmd.scan_length;
			tdo_s1  <= cmd.tdo_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q   <= TAP_RESET;
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			shift_q <= '0;
			cap_q   <= '0;
			is_ir_q <= 1'b0;
			bits_q  <= '0;
		end else if (advance) begin
			tap_q   <= tap_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			cap_q   <= cap_d;
			is_ir_q <= is_ir_d;
			bits_q  <= bits_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tms_q   <= tms;
			tdi_q   <= tdi;
			pulse_q <= pulse;
			busy_q  <= (phase_d != PH_IDLE);
			done_q  <= done;
			rej_q   <= rej;
			rdata_q <= cap_d;
			pos_q   <= tap_d;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.tms_out      = tms_q;
	assign res.tdi_out      = tdi_q;
	assign res.clock_pulse  = pulse_q;
	assign res.busy_res     = busy_q;
	assign res.done_res     = done_q;
	assign res.read_data    = rdata_q;
	assign res.rejected     = rej_q;
	assign res.tap_position = pos_q;

endmodule

@@ rtl/jsm_checker.sv @@
module jsm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_tms,
	input logic                         res_tdi,
	input logic                         res_pulse,
	input logic                         res_busy,
	input logic                         res_done,
	input logic [jsm_pkg::DATA_W-1:0]   res_rdata,
	input logic                         res_rej,
	input logic [jsm_pkg::TAP_W-1:0]    res_pos
);
	import jsm_pkg::*;

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_rdata) && $stable(res_pos)
			&& $stable(res_tms) && $stable(res_done))
		else $error("result word changed while stalled");

	// completion leaves the TAP in Run-Test/Idle with the sequence dropped
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_done |-> res_pulse && !res_busy && res_pos == TAP_IDLE)
		else $error("done without return to idle");

	// a rejected start clocks nothing and the running sequence carries on
	a_rej_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_rej |-> !res_pulse && !res_done && res_busy)
		else $error("rejected start disturbed the sequence");

	// no TCK cycle means TMS and TDI held low
	a_quiet_pins: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_pulse |-> !res_tms && !res_tdi)
		else $error("pins driven without a clock pulse");

endmodule

bind jtag_scan_master jsm_checker u_jsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_tms   (res.tms_out),
	.res_tdi   (res.tdi_out),
	.res_pulse (res.clock_pulse),
	.res_busy  (res.busy_res),
	.res_done  (res.done_res),
	.res_rdata (res.read_data),
	.res_rej   (res.rejected),
	.res_pos   (res.tap_position)
);

@@ bench/tb_jtag_scan_master.sv @@
module tb_jtag_scan_master;
	import jsm_pkg::*;

	typedef struct packed {
		logic               tms;
		logic               tdi;
		logic               pulse;
		logic               busy;
		logic               done;
		logic [DATA_W-1:0]  capture;
		logic               rejected;
		logic [TAP_W-1:0]   position;
	} tap_result_t;

	logic clk = 1'b0;
	logic arst_n;

	jsm_cmd_if cmd();
	jsm_res_if res();

	jtag_scan_master DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	always #4 clk = ~clk;

	// Shadow of the master's sequencing state
	tap_state_t        tap_now      = TAP_RESET;
	phase_t            seq_phase    = PH_IDLE;
	int unsigned       bits_done    = 0;
	logic [DATA_W-1:0] tdi_shift    = '0;
	logic [DATA_W-1:0] tdo_capture  = '0;
	opcode_t           scan_op      = OP_TICK;
	int unsigned       scan_len     = 0;

	tap_result_t tap_results_q[$];
	int          mismatches   = 0;
	int          words_issued = 0;
	bit          quiet        = 1'b0;
	int          stall_left   = 0;

	function automatic tap_state_t tap_advance(input tap_state_t s, input logic tms);
		case (s)
			TAP_RESET:     return tms ? TAP_RESET     : TAP_IDLE;
			TAP_IDLE:      return tms ? TAP_SEL_DR    : TAP_IDLE;
			TAP_SEL_DR:    return tms ? TAP_SEL_IR    : TAP_CAP_DR;
			TAP_CAP_DR:    return tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
			TAP_SHIFT_DR:  return tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
			TAP_EXIT1_DR:  return tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
			TAP_PAUSE_DR:  return tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
			TAP_EXIT2_DR:  return tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
			TAP_UPDATE_DR: return tms ? TAP_SEL_DR    : TAP_IDLE;
			TAP_SEL_IR:    return tms ? TAP_RESET     : TAP_CAP_IR;
			TAP_CAP_IR:    return tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
			TAP_SHIFT_IR:  return tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
			TAP_EXIT1_IR:  return tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
			TAP_PAUSE_IR:  return tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
			TAP_EXIT2_IR:  return tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
			default:       return tms ? TAP_SEL_DR    : TAP_IDLE;
		endcase
	endfunction

	function automatic tap_result_t predict_tck_cycle(input opcode_t op,
			input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] len, input logic tdo);
		tap_result_t r;
		int unsigned n;
		r = '0;
		n = len;
		if (op != OP_TICK) begin
			if (seq_phase != PH_IDLE) begin
				r.rejected = 1'b1;
			end else if (op == OP_RESET) begin
				seq_phase = PH_RESET;
				bits_done = 0;
			end else begin
				if (n == 0) n = 1;
				if (n > SCAN_WIDTH) n = SCAN_WIDTH;
				seq_phase   = PH_SCAN;
				scan_op     = op;
				scan_len    = n;
				bits_done   = 0;
				tdi_shift   = data;
				tdo_capture = '0;
			end
		end else if (seq_phase == PH_RESET) begin
			r.pulse = 1'b1;
			if (bits_done < RESET_ONES) begin
				r.tms = 1'b1;
				bits_done++;
			end else begin
				r.done = 1'b1;
			end
		end else if (seq_phase == PH_SCAN) begin
			r.pulse = 1'b1;
			case (tap_now)
				TAP_RESET:  r.tms = 1'b0;
				TAP_IDLE:   r.tms = 1'b1;
				TAP_SEL_DR: r.tms = (scan_op == OP_IR_SCAN);
				TAP_SEL_IR, TAP_CAP_DR, TAP_CAP_IR: r.tms = 1'b0;
				TAP_SHIFT_DR, TAP_SHIFT_IR: begin
					r.tdi = tdi_shift[0];
					tdi_shift = tdi_shift >> 1;
					if (bits_done < DATA_W) tdo_capture[bits_done] = tdo;
					bits_done++;
					r.tms = (bits_done >= scan_len);
				end
				TAP_UPDATE_DR, TAP_UPDATE_IR: begin
					r.tms  = 1'b0;
					r.done = 1'b1;
				end
				// pause and exit states: push on towards update
				default:    r.tms = 1'b1;
			endcase
		end
		if (r.pulse) tap_now = tap_advance(tap_now, r.tms);
		if (r.done) begin
			seq_phase = PH_IDLE;
			bits_done = 0;
		end
		r.busy     = (seq_phase != PH_IDLE);
		r.capture  = tdo_capture;
		r.position = tap_now;
		return r;
	endfunction

	task automatic issue_cmd(input opcode_t op, input logic [DATA_W-1:0] data,
			input logic [LEN_W-1:0] len, input logic tdo);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.opcode      <= op;
		cmd.scan_data   <= data;
		cmd.scan_length <= len;
		cmd.tdo_bit     <= tdo;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		tap_results_q.push_back(predict_tck_cycle(op, data, len, tdo));
		words_issued++;
	endtask

	// Clock the armed sequence through to idle, now and then slipping in a start
	task automatic finish_sequence(input int reject_pct);
		while (seq_phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < reject_pct)
				issue_cmd(opcode_t'($urandom_range(1, 3)), $urandom, LEN_W'($urandom),
					1'($urandom));
			else
				issue_cmd(OP_TICK, $urandom, LEN_W'($urandom), 1'($urandom));
		end
	endtask

	task automatic await_results();
		cmd.valid <= 1'b0;
		while (tap_results_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_scan_out_of_reset();
		// zero length clamps to a single bit
		issue_cmd(OP_IR_SCAN, '1, '0, 1'b1);
		finish_sequence(0);
	endtask

	task automatic test_idle_ticks();
		issue_cmd(OP_TICK, '0, '0, 1'b0);
		issue_cmd(OP_TICK, '1, '1, 1'b1);
	endtask

	task automatic test_tap_reset();
		issue_cmd(OP_RESET, '0, '0, 1'b0);
		issue_cmd(OP_TICK, '1, '1, 1'b1);
		issue_cmd(OP_RESET, '1, '1, 1'b1);
		issue_cmd(OP_IR_SCAN, '1, 6'd8, 1'b0);
		issue_cmd(OP_DR_SCAN, '0, 6'd1, 1'b1);
		finish_sequence(0);
	endtask

	task automatic test_long_dr_scan();
		// oversize length clamps to the full width
		issue_cmd(OP_DR_SCAN, 32'hA5C3_5A3C, '1, 1'b0);
		issue_cmd(OP_TICK, '0, '0, 1'b1);
		issue_cmd(OP_IR_SCAN, '0, '0, 1'b0);
		finish_sequence(0);
	endtask

	task automatic test_random_traffic();
		opcode_t          op;
		logic [LEN_W-1:0] len;
		while (words_issued < 740) begin
			quiet = (words_issued >= 620);
			if ($urandom_range(0, 99) < 15) begin
				issue_cmd(opcode_t'($urandom_range(0, 3)), $urandom, LEN_W'($urandom),
					1'($urandom));
			end else begin
				op = opcode_t'($urandom_range(1, 3));
				case ($urandom_range(0, 9))
					0:       len = LEN_W'($urandom_range(0, 63));
					1, 2:    len = LEN_W'($urandom_range(9, 32));
					default: len = LEN_W'($urandom_range(1, 8));
				endcase
				issue_cmd(op, $urandom, len, 1'($urandom));
				finish_sequence(4);
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			res.ready  <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		tap_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (tap_results_q.size() == 0) begin
				$error("result word with nothing outstanding");
				mismatches++;
			end else begin
				want = tap_results_q.pop_front();
				check_field("tms_out", DATA_W'(want.tms), DATA_W'(res.tms_out));
				check_field("tdi_out", DATA_W'(want.tdi), DATA_W'(res.tdi_out));
				check_field("clock_pulse", DATA_W'(want.pulse), DATA_W'(res.clock_pulse));
				check_field("busy_res", DATA_W'(want.busy), DATA_W'(res.busy_res));
				check_field("done_res", DATA_W'(want.done), DATA_W'(res.done_res));
				check_field("read_data", want.capture, res.read_data);
				check_field("rejected", DATA_W'(want.rejected), DATA_W'(res.rejected));
				check_field("tap_position", DATA_W'(want.position),
					DATA_W'(res.tap_position));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n          <= 1'b0;
		cmd.valid       <= 1'b0;
		cmd.opcode      <= OP_TICK;
		cmd.scan_data   <= '0;
		cmd.scan_length <= '0;
		cmd.tdo_bit     <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_scan_out_of_reset();
		test_idle_ticks();
		test_tap_reset();
		await_results();
		test_long_dr_scan();
		test_random_traffic();
		await_results();
		repeat (6) @(posedge clk);
		if (mismatches == 0 && tap_results_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
